### rtl/kpsq_pkg.sv
package kpsq_pkg;

   // default counter chain setup
   localparam int SLOW_DIVIDE_DEFAULT = 100;
   localparam int PRESCALE_DEFAULT    = 16;
   localparam int POSTSCALE_DEFAULT   = 16;

   // reset values
   localparam logic [15:0] PERIOD_RESET = 16'd50000;
   localparam logic [7:0]  LIMIT_RESET  = 8'd195;

   // request kinds
   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // keypad
   localparam logic [3:0] NO_KEY_NIBBLE = 4'hF;
   localparam logic [3:0] ROW_SEVEN_PREFIX = 4'h7;
   localparam logic [3:0] ROW_SIX_PREFIX   = 4'hB;
   localparam logic [3:0] ROW_FIVE_PREFIX  = 4'hD;
   localparam logic [3:0] ROW_FOUR_PREFIX  = 4'hE;

   typedef struct packed {
      logic        hit;
      logic [15:0] period;
      logic        fast;
   } preset_type;

   typedef struct packed {
      logic [7:0] key;
      preset_type preset;
   } scan_result_type;

   function automatic preset_type preset_lookup(input logic [7:0] code);
      preset_type p;
      p.hit = 1'b1;
      case (code)
         8'hEE: begin p.period = 16'd50000; p.fast = 1'b0; end
         8'hED: begin p.period = 16'd5000;  p.fast = 1'b0; end
         8'hEB: begin p.period = 16'd500;   p.fast = 1'b0; end
         8'hE7: begin p.period = 16'd12500; p.fast = 1'b1; end
         8'hDE: begin p.period = 16'd10000; p.fast = 1'b1; end
         8'hDD: begin p.period = 16'd500;   p.fast = 1'b1; end
         8'hDB: begin p.period = 16'd10000; p.fast = 1'b0; end
         8'hD7: begin p.period = 16'd2500;  p.fast = 1'b0; end
         8'hBE: begin p.period = 16'd1250;  p.fast = 1'b0; end
         8'hBD: begin p.period = 16'd1000;  p.fast = 1'b0; end
         8'hBB: begin p.period = 16'd25000; p.fast = 1'b1; end
         8'hB7: begin p.period = 16'd6250;  p.fast = 1'b1; end
         8'h7E: begin p.period = 16'd5000;  p.fast = 1'b1; end
         8'h7D: begin p.period = 16'd2500;  p.fast = 1'b1; end
         8'h7B: begin p.period = 16'd1250;  p.fast = 1'b1; end
         8'h77: begin p.period = 16'd1000;  p.fast = 1'b1; end
         default: begin
            p.hit    = 1'b0;
            p.period = '0;
            p.fast   = 1'b0;
         end
      endcase
      return p;
   endfunction

endpackage

### rtl/kpsq_key_decode.sv
module kpsq_key_decode (
   input  logic [3:0]                row_seven_cols,
   input  logic [3:0]                row_six_cols,
   input  logic [3:0]                row_five_cols,
   input  logic [3:0]                row_four_cols,
   input  logic [7:0]                held_key,
   output kpsq_pkg::scan_result_type result
);

   logic [7:0] key_next;

   // first row with any column pulled low wins
   always_comb begin
      if (row_seven_cols != kpsq_pkg::NO_KEY_NIBBLE) begin
         key_next = {kpsq_pkg::ROW_SEVEN_PREFIX, row_seven_cols};
      end else if (row_six_cols != kpsq_pkg::NO_KEY_NIBBLE) begin
         key_next = {kpsq_pkg::ROW_SIX_PREFIX, row_six_cols};
      end else if (row_five_cols != kpsq_pkg::NO_KEY_NIBBLE) begin
         key_next = {kpsq_pkg::ROW_FIVE_PREFIX, row_five_cols};
      end else if (row_four_cols != kpsq_pkg::NO_KEY_NIBBLE) begin
         key_next = {kpsq_pkg::ROW_FOUR_PREFIX, row_four_cols};
      end else begin
         key_next = held_key;
      end
   end

   assign result.key    = key_next;
   assign result.preset = kpsq_pkg::preset_lookup(key_next);

endmodule

### rtl/keypad_preset_square_wave_generator.sv
// channel | ports                              | direction | transfer when
// --------+------------------------------------+-----------+------------------------
// req     | req_op, req_row_*_cols             | in        | req_valid && req_ready
// rsp     | rsp_wave_level, rsp_selected_key,  | out       | rsp_valid && rsp_ready
//         | rsp_period_word, rsp_fast_mode     |           |
//
// one request a clock while req_ready is high: the whole update sits between the
// state and response registers, so a transfer's response is valid in the next cycle
// req_ready is high whenever the response register is empty or being drained,
// so a stalled rsp side only holds off requests for as long as it stalls
// synchronous active-high reset: key 0, period 50000, limit 195, counters and wave 0
module keypad_preset_square_wave_generator #(
   parameter int SLOW_DIVIDE = kpsq_pkg::SLOW_DIVIDE_DEFAULT,
   parameter int PRESCALE    = kpsq_pkg::PRESCALE_DEFAULT,
   parameter int POSTSCALE   = kpsq_pkg::POSTSCALE_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [3:0]  req_row_seven_cols,
   input  logic [3:0]  req_row_six_cols,
   input  logic [3:0]  req_row_five_cols,
   input  logic [3:0]  req_row_four_cols,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_wave_level,
   output logic [7:0]  rsp_selected_key,
   output logic [15:0] rsp_period_word,
   output logic        rsp_fast_mode
);

   // limits in the widths of the compares
   localparam logic [4:0] PRESCALE_LIM  = 5'(PRESCALE);
   localparam logic [4:0] POSTSCALE_LIM = 5'(POSTSCALE);
   localparam logic [7:0] SLOW_LIM      = 8'(SLOW_DIVIDE);

   // generator state
   logic [7:0]  held_key_ff,     held_key_in;
   logic [15:0] period_ff,       period_in;
   logic        mode_ff,         mode_in;
   logic [3:0]  prescale_ff,     prescale_in;
   logic [7:0]  timer_ff,        timer_in;
   logic [7:0]  limit_ff,        limit_in;
   logic [3:0]  postscale_ff,    postscale_in;
   logic [6:0]  slow_ff,         slow_in;
   logic        level_ff,        level_in;

   // response register
   logic        rsp_valid_ff,    rsp_valid_in;
   logic        rsp_level_ff;
   logic [7:0]  rsp_key_ff;
   logic [15:0] rsp_period_ff;
   logic        rsp_fast_ff;

   logic                      req_xfer;
   kpsq_pkg::scan_result_type scan;
   logic [6:0]                slow_step;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   kpsq_key_decode u_key_decode (
      .row_seven_cols (req_row_seven_cols),
      .row_six_cols   (req_row_six_cols),
      .row_five_cols  (req_row_five_cols),
      .row_four_cols  (req_row_four_cols),
      .held_key       (held_key_ff),
      .result         (scan)
   );

   assign slow_step = slow_ff + 7'd1;

   // next state for one request
   always_comb begin
      held_key_in  = held_key_ff;
      period_in    = period_ff;
      mode_in      = mode_ff;
      prescale_in  = prescale_ff;
      timer_in     = timer_ff;
      limit_in     = limit_ff;
      postscale_in = postscale_ff;
      slow_in      = slow_ff;
      level_in     = level_ff;
      if (req_xfer) begin
         if (req_op == kpsq_pkg::OP_SCAN) begin
            held_key_in = scan.key;
            // unknown codes leave the preset alone
            if (scan.preset.hit) begin
               period_in = scan.preset.period;
               mode_in   = scan.preset.fast;
            end
         end else if (({1'b0, prescale_ff} + 5'd1) < PRESCALE_LIM) begin
            prescale_in = prescale_ff + 4'd1;
         end else begin
            prescale_in = '0;
            // a timer above a lowered limit runs on and wraps before matching
            if (timer_ff == limit_ff) begin
               timer_in = '0;
               if (({1'b0, postscale_ff} + 5'd1) < POSTSCALE_LIM) begin
                  postscale_in = postscale_ff + 4'd1;
               end else begin
                  postscale_in = '0;
                  limit_in     = period_ff[15:8];
                  if (mode_ff) begin
                     level_in = !level_ff;
                  end else if ({1'b0, slow_step} >= SLOW_LIM) begin
                     slow_in  = '0;
                     level_in = !level_ff;
                  end else begin
                     slow_in = slow_step;
                  end
               end
            end else begin
               timer_in = timer_ff + 8'd1;
            end
         end
      end
   end

   // response valid: set by a request, cleared when drained without refill
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_key_ff  <= '0;
         period_ff    <= kpsq_pkg::PERIOD_RESET;
         mode_ff      <= 1'b0;
         prescale_ff  <= '0;
         timer_ff     <= '0;
         limit_ff     <= kpsq_pkg::LIMIT_RESET;
         postscale_ff <= '0;
         slow_ff      <= '0;
         level_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_key_ff  <= held_key_in;
         period_ff    <= period_in;
         mode_ff      <= mode_in;
         prescale_ff  <= prescale_in;
         timer_ff     <= timer_in;
         limit_ff     <= limit_in;
         postscale_ff <= postscale_in;
         slow_ff      <= slow_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload shows the state after the update
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_level_ff  <= level_in;
         rsp_key_ff    <= held_key_in;
         rsp_period_ff <= period_in;
         rsp_fast_ff   <= mode_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_wave_level   = rsp_level_ff;
   assign rsp_selected_key = rsp_key_ff;
   assign rsp_period_word  = rsp_period_ff;
   assign rsp_fast_mode    = rsp_fast_ff;

   // a pending response always mirrors the live state
   a_rsp_mirrors_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_level_ff == level_ff && rsp_key_ff == held_key_ff &&
                        rsp_period_ff == period_ff && rsp_fast_ff == mode_ff))
      else $error("pending response differs from generator state");

   a_xfer_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid_ff)
      else $error("accepted request left no response");

   a_prescale_range: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, prescale_ff} < PRESCALE_LIM) && ({1'b0, postscale_ff} < POSTSCALE_LIM))
      else $error("prescaler or postscaler past its limit");

   a_slow_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, slow_ff} < SLOW_LIM)
      else $error("slow counter past its limit");

endmodule

### tb/keypad_preset_square_wave_generator_tb.sv
module keypad_preset_square_wave_generator_tb;

   // package names used below
   localparam logic        OP_SCAN             = kpsq_pkg::OP_SCAN;
   localparam logic        OP_TICK             = kpsq_pkg::OP_TICK;
   localparam logic [3:0]  NO_KEY_NIBBLE       = kpsq_pkg::NO_KEY_NIBBLE;
   localparam logic [3:0]  ROW_SEVEN_PREFIX    = kpsq_pkg::ROW_SEVEN_PREFIX;
   localparam logic [3:0]  ROW_SIX_PREFIX      = kpsq_pkg::ROW_SIX_PREFIX;
   localparam logic [3:0]  ROW_FIVE_PREFIX     = kpsq_pkg::ROW_FIVE_PREFIX;
   localparam logic [3:0]  ROW_FOUR_PREFIX     = kpsq_pkg::ROW_FOUR_PREFIX;
   localparam logic [15:0] PERIOD_RESET        = kpsq_pkg::PERIOD_RESET;
   localparam logic [7:0]  LIMIT_RESET         = kpsq_pkg::LIMIT_RESET;
   localparam int          PRESCALE_DEFAULT    = kpsq_pkg::PRESCALE_DEFAULT;
   localparam int          POSTSCALE_DEFAULT   = kpsq_pkg::POSTSCALE_DEFAULT;
   localparam int          SLOW_DIVIDE_DEFAULT = kpsq_pkg::SLOW_DIVIDE_DEFAULT;

   // run control
   localparam int CYCLE_LIMIT  = 4_000_000;  // many times the slowest legal run
   localparam int RANDOM_ITEMS = 900;
   localparam int HOLD_AFTER   = 500;        // results seen before the long rsp hold-off
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 8;          // response register is one deep

   // one request: op plus the four active-low column nibbles
   typedef struct packed {
      logic       op;
      logic [3:0] row_seven;
      logic [3:0] row_six;
      logic [3:0] row_five;
      logic [3:0] row_four;
   } keypad_req_type;

   // one response as seen on the rsp channel
   typedef struct packed {
      logic        wave;
      logic [7:0]  key;
      logic [15:0] period;
      logic        fast;
   } wave_status_type;

   typedef struct packed {
      logic [7:0]  code;
      logic [15:0] period;
      logic        fast;
   } preset_entry_type;

   // directed row: typed flag set where the response is obvious by inspection
   typedef struct packed {
      keypad_req_type  item;
      logic            typed;
      wave_status_type want;
   } directed_row_type;

   typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_PERIODIC} rx_mode_type;

   // the sixteen keypad presets: code, period word, fast flag
   preset_entry_type preset_table [16] = '{
      '{8'hEE, 16'd50000, 1'b0}, '{8'hED, 16'd5000,  1'b0}, '{8'hEB, 16'd500,   1'b0},
      '{8'hE7, 16'd12500, 1'b1}, '{8'hDE, 16'd10000, 1'b1}, '{8'hDD, 16'd500,   1'b1},
      '{8'hDB, 16'd10000, 1'b0}, '{8'hD7, 16'd2500,  1'b0}, '{8'hBE, 16'd1250,  1'b0},
      '{8'hBD, 16'd1000,  1'b0}, '{8'hBB, 16'd25000, 1'b1}, '{8'hB7, 16'd6250,  1'b1},
      '{8'h7E, 16'd5000,  1'b1}, '{8'h7D, 16'd2500,  1'b1}, '{8'h7B, 16'd1250,  1'b1},
      '{8'h77, 16'd1000,  1'b1}
   };

   // directed part: extremes of the nibbles, both ops, no key, unknown codes,
   // several rows pressed at once (first row wins), ignored columns on ticks
   directed_row_type directed_rows [20] = '{
      '{'{OP_SCAN, 4'hF, 4'hF, 4'hF, 4'hF}, 1'b1, '{1'b0, 8'h00, 16'd50000, 1'b0}},
      '{'{OP_TICK, 4'h0, 4'h0, 4'h0, 4'h0}, 1'b1, '{1'b0, 8'h00, 16'd50000, 1'b0}},
      '{'{OP_SCAN, 4'hE, 4'hF, 4'hF, 4'hF}, 1'b1, '{1'b0, 8'h7E, 16'd5000,  1'b1}},
      '{'{OP_SCAN, 4'h0, 4'h0, 4'h0, 4'h0}, 1'b1, '{1'b0, 8'h70, 16'd5000,  1'b1}},
      '{'{OP_SCAN, 4'hF, 4'hE, 4'hF, 4'hF}, 1'b1, '{1'b0, 8'hBE, 16'd1250,  1'b0}},
      '{'{OP_SCAN, 4'hF, 4'hF, 4'hD, 4'hF}, 1'b1, '{1'b0, 8'hDD, 16'd500,   1'b1}},
      '{'{OP_SCAN, 4'hF, 4'hF, 4'hF, 4'h7}, 1'b1, '{1'b0, 8'hE7, 16'd12500, 1'b1}},
      '{'{OP_TICK, 4'hF, 4'hF, 4'hF, 4'hF}, 1'b0, '0},
      '{'{OP_SCAN, 4'hF, 4'hF, 4'hF, 4'hE}, 1'b1, '{1'b0, 8'hEE, 16'd50000, 1'b0}},
      '{'{OP_SCAN, 4'h7, 4'h0, 4'h0, 4'h0}, 1'b1, '{1'b0, 8'h77, 16'd1000,  1'b1}},
      '{'{OP_SCAN, 4'hF, 4'hF, 4'hF, 4'h0}, 1'b1, '{1'b0, 8'hE0, 16'd1000,  1'b1}},
      '{'{OP_SCAN, 4'hF, 4'hF, 4'hF, 4'hF}, 1'b1, '{1'b0, 8'hE0, 16'd1000,  1'b1}},
      '{'{OP_SCAN, 4'hF, 4'h5, 4'hF, 4'hF}, 1'b1, '{1'b0, 8'hB5, 16'd1000,  1'b1}},
      '{'{OP_SCAN, 4'hF, 4'hD, 4'hE, 4'h0}, 1'b1, '{1'b0, 8'hBD, 16'd1000,  1'b0}},
      '{'{OP_TICK, 4'hA, 4'h5, 4'hA, 4'h5}, 1'b0, '0},
      '{'{OP_SCAN, 4'hF, 4'hF, 4'h7, 4'hF}, 1'b1, '{1'b0, 8'hD7, 16'd2500,  1'b0}},
      '{'{OP_SCAN, 4'hF, 4'hB, 4'h0, 4'h0}, 1'b1, '{1'b0, 8'hBB, 16'd25000, 1'b1}},
      '{'{OP_SCAN, 4'hF, 4'hF, 4'hF, 4'hD}, 1'b1, '{1'b0, 8'hED, 16'd5000,  1'b0}},
      '{'{OP_TICK, 4'h5, 4'hA, 4'h5, 4'hA}, 1'b0, '0},
      '{'{OP_SCAN, 4'hF, 4'hF, 4'hF, 4'hB}, 1'b1, '{1'b0, 8'hEB, 16'd500,   1'b0}}
   };

   // short tick runs behind one key each, swapping between fast and slow presets
   logic [7:0] soak_key   [5] = '{8'hDD, 8'hEB, 8'hDD, 8'hEB, 8'h77};
   int         soak_ticks [5] = '{40, 40, 40, 40, 40};

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_ready;
   logic        req_op;
   logic [3:0]  req_row_seven_cols;
   logic [3:0]  req_row_six_cols;
   logic [3:0]  req_row_five_cols;
   logic [3:0]  req_row_four_cols;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_wave_level;
   logic [7:0]  rsp_selected_key;
   logic [15:0] rsp_period_word;
   logic        rsp_fast_mode;

   // generator state as predicted
   logic [7:0]  gen_key;
   logic [15:0] gen_period;
   logic        gen_fast;
   logic [3:0]  gen_prescale;
   logic [7:0]  gen_timer;
   logic [7:0]  gen_limit;
   logic [3:0]  gen_postscale;
   logic [6:0]  gen_slow;
   logic        gen_wave;

   wave_status_type status_due_q [$];
   wave_status_type rsp_seen;
   wave_status_type rsp_due;

   int fail_count   = 0;
   int results_seen = 0;
   int cycle_count  = 0;
   int burst_left   = 0;

   // receiver side
   rx_mode_type rx_mode = RX_STEADY;
   int          rx_mode_left = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   logic [1:0]  rx_phase = '0;
   logic        rx_ready_next;

   keypad_preset_square_wave_generator u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_row_seven_cols (req_row_seven_cols),
      .req_row_six_cols   (req_row_six_cols),
      .req_row_five_cols  (req_row_five_cols),
      .req_row_four_cols  (req_row_four_cols),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_wave_level     (rsp_wave_level),
      .rsp_selected_key   (rsp_selected_key),
      .rsp_period_word    (rsp_period_word),
      .rsp_fast_mode      (rsp_fast_mode)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_generator();
      gen_key       = '0;
      gen_period    = PERIOD_RESET;
      gen_fast      = 1'b0;
      gen_prescale  = '0;
      gen_timer     = '0;
      gen_limit     = LIMIT_RESET;
      gen_postscale = '0;
      gen_slow      = '0;
      gen_wave      = 1'b0;
   endfunction

   // first row with any column low sets the key; a known key picks its preset
   function automatic void decode_keypad(input keypad_req_type r);
      logic [3:0] cols   [4];
      logic [3:0] prefix [4];
      bit         found;
      cols   = '{r.row_seven, r.row_six, r.row_five, r.row_four};
      prefix = '{ROW_SEVEN_PREFIX, ROW_SIX_PREFIX, ROW_FIVE_PREFIX, ROW_FOUR_PREFIX};
      found  = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (!found && cols[i] != NO_KEY_NIBBLE) begin
            gen_key = {prefix[i], cols[i]};
            found   = 1'b1;
         end
      end
      for (int i = 0; i < 16; i++) begin
         if (preset_table[i].code == gen_key) begin
            gen_period = preset_table[i].period;
            gen_fast   = preset_table[i].fast;
         end
      end
   endfunction

   // prescaler -> 8-bit timer matching the limit -> postscaler -> wave
   function automatic void count_tick();
      if (int'(gen_prescale) + 1 < PRESCALE_DEFAULT) begin
         gen_prescale = gen_prescale + 1'b1;
      end else begin
         gen_prescale = '0;
         if (gen_timer != gen_limit) begin
            gen_timer = gen_timer + 1'b1;  // wraps past 255 if above the limit
         end else begin
            gen_timer = '0;
            if (int'(gen_postscale) + 1 < POSTSCALE_DEFAULT) begin
               gen_postscale = gen_postscale + 1'b1;
            end else begin
               gen_postscale = '0;
               gen_limit     = gen_period[15:8];
               if (gen_fast) begin
                  gen_wave = ~gen_wave;
               end else begin
                  // slow count only moves in slow mode and survives mode changes
                  gen_slow = gen_slow + 1'b1;
                  if (int'(gen_slow) >= SLOW_DIVIDE_DEFAULT) begin
                     gen_slow = '0;
                     gen_wave = ~gen_wave;
                  end
               end
            end
         end
      end
   endfunction

   function automatic wave_status_type advance_generator(input keypad_req_type r);
      if (r.op == OP_TICK)
         count_tick();
      else
         decode_keypad(r);
      return '{gen_wave, gen_key, gen_period, gen_fast};
   endfunction

   // ---------------------------------------------------------------- stimulus

   // scan that presses one key: rows above it released, rows below it random
   function automatic keypad_req_type key_press(input logic [7:0] code);
      keypad_req_type r;
      r.op        = OP_SCAN;
      r.row_seven = 4'($urandom_range(0, 15));
      r.row_six   = 4'($urandom_range(0, 15));
      r.row_five  = 4'($urandom_range(0, 15));
      r.row_four  = 4'($urandom_range(0, 15));
      case (code[7:4])
         ROW_SEVEN_PREFIX: r.row_seven = code[3:0];
         ROW_SIX_PREFIX: begin
            r.row_seven = NO_KEY_NIBBLE;
            r.row_six   = code[3:0];
         end
         ROW_FIVE_PREFIX: begin
            r.row_seven = NO_KEY_NIBBLE;
            r.row_six   = NO_KEY_NIBBLE;
            r.row_five  = code[3:0];
         end
         default: begin
            r.row_seven = NO_KEY_NIBBLE;
            r.row_six   = NO_KEY_NIBBLE;
            r.row_five  = NO_KEY_NIBBLE;
            r.row_four  = code[3:0];
         end
      endcase
      return r;
   endfunction

   function automatic keypad_req_type random_item();
      keypad_req_type r;
      r.op        = ($urandom_range(0, 99) < 75) ? OP_TICK : OP_SCAN;
      r.row_seven = 4'($urandom_range(0, 15));
      r.row_six   = 4'($urandom_range(0, 15));
      r.row_five  = 4'($urandom_range(0, 15));
      r.row_four  = 4'($urandom_range(0, 15));
      if (r.op == OP_SCAN) begin
         case ($urandom_range(0, 4))
            0, 1: r = key_press(preset_table[$urandom_range(0, 15)].code);
            2: r = '{OP_SCAN, NO_KEY_NIBBLE, NO_KEY_NIBBLE, NO_KEY_NIBBLE, NO_KEY_NIBBLE};
            3: begin
               // release some upper rows so unknown codes come from the lower ones
               if ($urandom_range(0, 1)) r.row_seven = NO_KEY_NIBBLE;
               if ($urandom_range(0, 1)) r.row_six   = NO_KEY_NIBBLE;
               if ($urandom_range(0, 1)) r.row_five  = NO_KEY_NIBBLE;
            end
            default: ;  // all columns random
         endcase
      end
      return r;
   endfunction

   // present one item, wait for its transfer, then maybe end the burst with a gap
   task automatic offer(input keypad_req_type item, input logic typed,
                        input wave_status_type want);
      wave_status_type due;
      int              gap;
      @(negedge clock);
      req_valid          = 1'b1;
      req_op             = item.op;
      req_row_seven_cols = item.row_seven;
      req_row_six_cols   = item.row_six;
      req_row_five_cols  = item.row_five;
      req_row_four_cols  = item.row_four;
      do @(posedge clock); while (!req_ready);
      due = advance_generator(item);
      status_due_q.push_back(typed ? want : due);
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // stop offering until every expected response has been taken
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (status_due_q.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      keypad_req_type tick;
      req_valid          = 1'b0;
      req_op             = OP_SCAN;
      req_row_seven_cols = NO_KEY_NIBBLE;
      req_row_six_cols   = NO_KEY_NIBBLE;
      req_row_five_cols  = NO_KEY_NIBBLE;
      req_row_four_cols  = NO_KEY_NIBBLE;
      clear_generator();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows
      foreach (directed_rows[i])
         offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      // random mix of ticks and scans; the long rsp hold-off lands in here
      repeat (RANDOM_ITEMS)
         offer(random_item(), 1'b0, '0);

      // quiet point: everything returned before the soak starts
      drain();

      // tick soak, with the odd released-keypad scan that must change nothing
      foreach (soak_key[s]) begin
         offer(key_press(soak_key[s]), 1'b0, '0);
         repeat (soak_ticks[s]) begin
            tick = random_item();
            if ($urandom_range(0, 39) == 0)
               tick = '{OP_SCAN, NO_KEY_NIBBLE, NO_KEY_NIBBLE, NO_KEY_NIBBLE, NO_KEY_NIBBLE};
            else
               tick.op = OP_TICK;
            offer(tick, 1'b0, '0);
         end
      end

      drain();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("keypad_preset_square_wave_generator_tb: PASS");
      else
         $display("keypad_preset_square_wave_generator_tb: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   // rsp_ready: steady, random or periodic stalls, plus one long hold-off
   // while the sender keeps pushing so the block backs up and drops req_ready
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rx_ready_next = 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         hold_done     = 1'b1;
         hold_left     = HOLD_CYCLES - 1;
         rx_ready_next = 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_type'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(64, 256);
         end
         rx_mode_left--;
         case (rx_mode)
            RX_STEADY:   rx_ready_next = 1'b1;
            RX_RANDOM:   rx_ready_next = ($urandom_range(0, 2) != 0);
            default:     rx_ready_next = (rx_phase != 2'd3);
         endcase
         rx_phase = rx_phase + 1'b1;
      end
      rsp_ready <= rx_ready_next;
   end

   // ---------------------------------------------------------------- checking

   task automatic log_failure(input string what, input wave_status_type got,
                              input wave_status_type exp);
      fail_count++;
      if (fail_count <= 10)
         $display("%s: exp wave/key/period/fast %0b/%02h/%0d/%0b, got %0b/%02h/%0d/%0b",
                  what, exp.wave, exp.key, exp.period, exp.fast,
                  got.wave, got.key, got.period, got.fast);
   endtask

   // every rsp transfer is matched against the oldest outstanding expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         rsp_seen = '{rsp_wave_level, rsp_selected_key, rsp_period_word, rsp_fast_mode};
         if (status_due_q.size() == 0) begin
            log_failure("unexpected response", rsp_seen, '0);
         end else begin
            rsp_due = status_due_q.pop_front();
            if (rsp_seen.wave !== rsp_due.wave || rsp_seen.key !== rsp_due.key ||
                rsp_seen.period !== rsp_due.period || rsp_seen.fast !== rsp_due.fast)
               log_failure("response mismatch", rsp_seen, rsp_due);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("keypad_preset_square_wave_generator_tb: FAIL");
         $finish;
      end
   end

endmodule
